// ===== rtl/core/psp_pkg.sv =====
// Shared constants, op codes and the pan gain table for the sample player.
// No dependencies.
package psp_pkg;

  localparam int VOICES      = 16;
  localparam int SLOTS       = 64;
  localparam int PAN_ENTRIES = 256;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_TRIGGER   = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_STOP_SLOT = 3'd3;
  localparam logic [2:0] OP_STOP_ALL  = 3'd4;
  localparam logic [2:0] OP_WR_FRAME  = 3'd5;
  localparam logic [2:0] OP_WR_SLOT   = 3'd6;

  localparam logic [1:0] REG_VOICE_LIMIT = 2'd0;
  localparam logic [1:0] REG_MASTER_VOL  = 2'd1;
  localparam logic [1:0] REG_SLOT_COUNT  = 2'd2;

  typedef logic [15:0] pan_rom_t [0:PAN_ENTRIES];

  // Quarter-wave sine in Q1.15 from a Q30 Taylor series through x^15
  function automatic pan_rom_t build_pan_rom();
    pan_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] q;
    logic signed [63:0] sum;
    int k;
    int n;
    for (k = 0; k <= PAN_ENTRIES; k++) begin
      x = (64'd1686629713 * 64'(k)) >> 8;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      q = (($unsigned(sum) << 15) + (64'd1 << 29)) >> 30;
      rom[k] = (q > 64'd32768) ? 16'd32768 : q[15:0];
    end
    return rom;
  endfunction

  localparam pan_rom_t PAN_ROM = build_pan_rom();

endpackage

// ===== rtl/core/polyphonic_sample_player.sv =====
// Polyphonic stereo sample player: voice table, sample and slot memories,
// one shared signed multiplier under a sequencer. Uses psp_pkg.
// Non-tick requests go from accept through S_EXEC and S_DONE to the result.
// A tick walks the enabled voices: an idle one visits S_V0 only, one that ends S_V0 and
// S_V1, else S_V0 to S_M8 (slot read, two frame reads, eight multiplier passes, accumulate).
// One request at a time; the shared multiplier and single memory port set it.
// Reset (rst_n, synchronous) stops all voices and loads limit 16, volume
// 32768, slot count 0; sample and slot memories are not cleared.
module polyphonic_sample_player
  import psp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // voice_number, slot_number, voice_gain, pan_position, pitch_step, loop_flag,
  // frame_address, left_value, right_value, slot_length
  input  logic [135:0] in_tdata,
  // operation
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_out, right_out, chosen_voice, trigger_failed, active_mask, active_count
  output logic [63:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wr_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_V0   = 4'd2;
  localparam logic [3:0] S_V1   = 4'd3;
  localparam logic [3:0] S_V2   = 4'd4;
  localparam logic [3:0] S_V3   = 4'd5;
  localparam logic [3:0] S_M0   = 4'd6;
  localparam logic [3:0] S_M1   = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_M3   = 4'd9;
  localparam logic [3:0] S_M4   = 4'd10;
  localparam logic [3:0] S_M5   = 4'd11;
  localparam logic [3:0] S_M6   = 4'd12;
  localparam logic [3:0] S_M7   = 4'd13;
  localparam logic [3:0] S_M8   = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]  state_r;
  logic [4:0]  limit_r;
  logic [15:0] master_r;
  logic [6:0]  slot_count_r;

  logic [2:0]   op_r;
  logic [135:0] req_r;

  logic [15:0] playing_r;
  logic [5:0]  v_slot_r  [VOICES];
  logic [33:0] v_pos_r   [VOICES];
  logic [23:0] v_step_r  [VOICES];
  logic [15:0] v_vol_r   [VOICES];
  logic        v_loop_r  [VOICES];
  logic [15:0] v_lgain_r [VOICES];
  logic [15:0] v_rgain_r [VOICES];

  logic [31:0] sample_mem [65536];
  logic [15:0] slot_start_mem [SLOTS];
  logic [16:0] slot_len_mem [SLOTS];
  logic [31:0] mem_q_r;
  logic [15:0] start_q_r;
  logic [16:0] len_q_r;

  logic [3:0]  v_r;
  logic [15:0] addr1_r;
  logic [15:0] frac_r;
  logic [31:0] w0_r;
  logic [31:0] w1_r;
  logic signed [16:0] interp_l_r;
  logic signed [16:0] interp_r_r;
  logic signed [23:0] acc_l_r;
  logic signed [23:0] acc_r_r;
  logic signed [67:0] prod_r;
  logic signed [49:0] mul_a;
  logic signed [17:0] mul_b;

  logic [3:0]  chosen_r;
  logic        failed_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  // request fields
  logic [3:0]  f_voice;
  logic [5:0]  f_slot;
  logic [15:0] f_gain;
  logic [15:0] f_pan;
  logic [23:0] f_step;
  logic        f_loop;
  logic [15:0] f_addr;
  logic [15:0] f_left;
  logic [15:0] f_right;
  logic [16:0] f_len;
  assign f_voice = req_r[3:0];
  assign f_slot  = req_r[9:4];
  assign f_gain  = req_r[25:10];
  assign f_pan   = req_r[41:26];
  assign f_step  = req_r[65:42];
  assign f_loop  = req_r[66];
  assign f_addr  = req_r[82:67];
  assign f_left  = req_r[98:83];
  assign f_right = req_r[114:99];
  assign f_len   = req_r[131:115];

  logic [4:0] lim;
  always_comb begin
    if (limit_r == 5'd0) lim = 5'd1;
    else if (limit_r > 5'(VOICES)) lim = 5'(VOICES);
    else lim = limit_r;
  end

  logic [15:0] enabled;
  logic [3:0]  free_v;
  logic [15:0] slot_hit;
  logic [4:0]  count;
  always_comb begin
    free_v = 4'd0;
    count = 5'd0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      enabled[i] = (5'(i) < lim);
      if (enabled[i] && !playing_r[i]) free_v = 4'(i);
      slot_hit[i] = enabled[i] && (v_slot_r[i] == f_slot);
    end
    for (int i = 0; i < VOICES; i++) begin
      count = count + 5'(playing_r[i] & enabled[i]);
    end
  end

  logic [16:0] pan_sum;
  logic [8:0]  pan_k;
  assign pan_sum = {1'b0, ~f_pan[15], f_pan[14:0]} + 17'd128;
  assign pan_k = pan_sum[16:8];

  logic [33:0] cur_pos;
  logic [17:0] pos_int;
  logic        at_end;
  logic [33:0] pos_eff;
  logic [15:0] p0;
  logic [15:0] p1;
  logic        last_v;
  assign cur_pos = v_pos_r[v_r];
  assign pos_int = cur_pos[33:16];
  assign at_end  = (pos_int >= {1'b0, len_q_r});
  assign pos_eff = at_end ? 34'd0 : cur_pos;
  assign p0 = pos_eff[31:16];
  always_comb begin
    if ({1'b0, p0} + 17'd1 >= len_q_r) p1 = v_loop_r[v_r] ? 16'd0 : p0;
    else p1 = p0 + 16'd1;
  end
  assign last_v = ({1'b0, v_r} + 5'd1 >= lim);

  logic signed [16:0] w0l;
  logic signed [16:0] w0r;
  logic signed [16:0] w1l;
  logic signed [16:0] w1r;
  assign w0l = {w0_r[31], w0_r[31:16]};
  assign w0r = {w0_r[15], w0_r[15:0]};
  assign w1l = {w1_r[31], w1_r[31:16]};
  assign w1r = {w1_r[15], w1_r[15:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M0: begin
        mul_a = 50'(w1l - w0l);
        mul_b = {2'b00, frac_r};
      end
      S_M1: begin
        mul_a = 50'(w1r - w0r);
        mul_b = {2'b00, frac_r};
      end
      S_M2: begin
        mul_a = 50'(interp_l_r);
        mul_b = {2'b00, v_vol_r[v_r]};
      end
      S_M3: begin
        mul_a = prod_r[49:0];
        mul_b = {2'b00, v_lgain_r[v_r]};
      end
      S_M4, S_M7: begin
        mul_a = prod_r[49:0];
        mul_b = {2'b00, master_r};
      end
      S_M5: begin
        mul_a = 50'(interp_r_r);
        mul_b = {2'b00, v_vol_r[v_r]};
      end
      S_M6: begin
        mul_a = prod_r[49:0];
        mul_b = {2'b00, v_rgain_r[v_r]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  logic        mem_rd;
  logic [15:0] mem_rd_addr;
  assign mem_rd = (state_r == S_V1) || (state_r == S_V2);
  assign mem_rd_addr = (state_r == S_V1) ? (start_q_r + p0) : addr1_r;

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && op_r == OP_WR_FRAME) begin
      sample_mem[f_addr] <= {f_left, f_right};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      mem_q_r <= sample_mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && op_r == OP_WR_SLOT) begin
      slot_start_mem[f_slot] <= f_addr;
      slot_len_mem[f_slot] <= (f_len > 17'd65536) ? 17'd65536 : f_len;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_V0) begin
      start_q_r <= slot_start_mem[v_slot_r[v_r]];
      len_q_r <= slot_len_mem[v_slot_r[v_r]];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_EXEC: begin
        if (op_r == OP_TRIGGER && {1'b0, f_slot} < slot_count_r) begin
          v_slot_r[free_v]  <= f_slot;
          v_pos_r[free_v]   <= '0;
          v_vol_r[free_v]   <= f_gain;
          v_step_r[free_v]  <= f_step;
          v_loop_r[free_v]  <= f_loop;
          v_lgain_r[free_v] <= PAN_ROM[9'(PAN_ENTRIES) - pan_k];
          v_rgain_r[free_v] <= PAN_ROM[pan_k];
        end
      end
      S_V1: begin
        v_pos_r[v_r] <= pos_eff;
        frac_r <= pos_eff[15:0];
        addr1_r <= start_q_r + p1;
      end
      S_V2: w0_r <= mem_q_r;
      S_V3: w1_r <= mem_q_r;
      S_M1: interp_l_r <= w0l + $signed(prod_r[32:16]);
      S_M2: interp_r_r <= w0r + $signed(prod_r[32:16]);
      S_M8: v_pos_r[v_r] <= v_pos_r[v_r] + 34'(v_step_r[v_r]);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (state_r == S_M5) begin
      acc_l_r <= acc_l_r + 24'($signed(prod_r[65:45]));
    end else if (state_r == S_M8) begin
      acc_r_r <= acc_r_r + 24'($signed(prod_r[65:45]));
    end
  end

  function automatic logic [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) return 16'h7fff;
    if (v < -24'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= in_tuser;
      req_r <= in_tdata;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'd0, count, playing_r, failed_r, chosen_r,
                     sat16(acc_r_r), sat16(acc_l_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= 5'd16;
      master_r <= 16'd32768;
      slot_count_r <= 7'd0;
      playing_r <= '0;
      out_valid_r <= 1'b0;
      v_r <= '0;
      chosen_r <= '0;
      failed_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_VOICE_LIMIT: limit_r <= cfg_wr_data[4:0];
          REG_MASTER_VOL:  master_r <= cfg_wr_data;
          REG_SLOT_COUNT:  slot_count_r <= cfg_wr_data[6:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          chosen_r <= '0;
          failed_r <= 1'b0;
          v_r <= '0;
          state_r <= S_DONE;
          case (op_r)
            OP_TICK: state_r <= S_V0;
            OP_TRIGGER: begin
              if ({1'b0, f_slot} < slot_count_r) begin
                chosen_r <= free_v;
                playing_r[free_v] <= 1'b1;
              end else begin
                failed_r <= 1'b1;
              end
            end
            OP_STOP: playing_r[f_voice] <= 1'b0;
            OP_STOP_SLOT: playing_r <= playing_r & ~slot_hit;
            OP_STOP_ALL: playing_r <= '0;
            default: begin
            end
          endcase
        end
        S_V0: begin
          if (playing_r[v_r]) state_r <= S_V1;
          else if (last_v) state_r <= S_DONE;
          else v_r <= v_r + 4'd1;
        end
        S_V1: begin
          if (len_q_r == 17'd0 || (at_end && !v_loop_r[v_r])) begin
            playing_r[v_r] <= 1'b0;
            if (last_v) state_r <= S_DONE;
            else begin
              v_r <= v_r + 4'd1;
              state_r <= S_V0;
            end
          end else begin
            state_r <= S_V2;
          end
        end
        S_V2: state_r <= S_V3;
        S_V3: state_r <= S_M0;
        S_M0: state_r <= S_M1;
        S_M1: state_r <= S_M2;
        S_M2: state_r <= S_M3;
        S_M3: state_r <= S_M4;
        S_M4: state_r <= S_M5;
        S_M5: state_r <= S_M6;
        S_M6: state_r <= S_M7;
        S_M7: state_r <= S_M8;
        S_M8: begin
          if (last_v) state_r <= S_DONE;
          else begin
            v_r <= v_r + 4'd1;
            state_r <= S_V0;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/polyphonic_sample_player_test.sv =====
// Self-checking bench for polyphonic_sample_player: directed and random requests,
// with an in-bench mixer model predicting every result. Depends on psp_pkg.
module polyphonic_sample_player_test;
  import psp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 260;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         voice;
    logic [5:0]         slot;
    logic [15:0]        gain;
    logic signed [15:0] pan;
    logic [23:0]        step;
    logic               loop;
    logic [15:0]        addr;
    logic signed [15:0] lval;
    logic signed [15:0] rval;
    logic [16:0]        len;
  } request_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [3:0]  chosen;
    logic        failed;
    logic [15:0] mask;
    logic [4:0]  count;
  } mix_result_t;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_wr_data;

  polyphonic_sample_player u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  request_t    pending_requests[$];
  mix_result_t expected_mixes[$];
  request_t    on_bus;
  int          queued_count = 0;
  int          accepted_count = 0;
  int          errors = 0;
  int          cycles = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  bit          calm = 0;

  logic [15:0] pan_gain [0:PAN_ENTRIES];
  logic [4:0]  limit_reg;
  logic [15:0] volume_reg;
  logic [6:0]  loaded_reg;
  logic        playing [VOICES];
  logic [5:0]  v_slot [VOICES];
  logic [33:0] v_pos [VOICES];
  logic [23:0] v_step [VOICES];
  logic [15:0] v_gain [VOICES];
  logic        v_loop [VOICES];
  logic [15:0] v_lgain [VOICES];
  logic [15:0] v_rgain [VOICES];
  logic [31:0] frames [0:65535];
  logic [15:0] slot_base [SLOTS];
  logic [16:0] slot_len [SLOTS];
  bit          slot_safe [SLOTS];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void fill_pan_gains();
    longint unsigned x, x2, t, q;
    longint s;
    for (int k = 0; k <= PAN_ENTRIES; k++) begin
      x = (64'd1686629713 * longint'(k)) / PAN_ENTRIES;
      x2 = (x * x) >> 30;
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        s = (n % 2) ? s - longint'(t) : s + longint'(t);
      end
      if (s < 0) s = 0;
      q = ((longint'(s) << 15) + (64'd1 << 29)) >> 30;
      pan_gain[k] = (q > 32768) ? 16'd32768 : q[15:0];
    end
  endfunction

  function automatic int enabled_voices();
    if (limit_reg == 0) return 1;
    if (limit_reg > VOICES) return VOICES;
    return limit_reg;
  endfunction

  function automatic mix_result_t predict_mix(request_t r);
    mix_result_t res;
    longint acc_l, acc_r, l, rr, l0, l1, r0, r1;
    longint unsigned gl, gr;
    int lim, k;
    logic [16:0] len;
    logic [17:0] p0, p1;
    logic [15:0] frac;
    logic [31:0] w0, w1;
    acc_l = 0;
    acc_r = 0;
    res = '{default: 0};
    lim = enabled_voices();
    case (r.op)
      OP_TICK: begin
        for (int v = 0; v < lim; v++) begin
          if (!playing[v]) continue;
          len = slot_len[v_slot[v]];
          if (len == 0) begin
            playing[v] = 0;
            continue;
          end
          if (v_pos[v][33:16] >= len) begin
            if (v_loop[v]) v_pos[v] = 0;
            else begin
              playing[v] = 0;
              continue;
            end
          end
          p0 = v_pos[v][33:16];
          frac = v_pos[v][15:0];
          p1 = p0 + 18'd1;
          if (p1 >= len) p1 = v_loop[v] ? 18'd0 : p0;
          w0 = frames[16'(slot_base[v_slot[v]] + p0)];
          w1 = frames[16'(slot_base[v_slot[v]] + p1)];
          l0 = longint'($signed(w0[31:16]));
          r0 = longint'($signed(w0[15:0]));
          l1 = longint'($signed(w1[31:16]));
          r1 = longint'($signed(w1[15:0]));
          l = l0 + (((l1 - l0) * longint'(frac)) >>> 16);
          rr = r0 + (((r1 - r0) * longint'(frac)) >>> 16);
          gl = longint'(v_gain[v]) * longint'(v_lgain[v]) * longint'(volume_reg);
          gr = longint'(v_gain[v]) * longint'(v_rgain[v]) * longint'(volume_reg);
          acc_l += (l * longint'(gl)) >>> 45;
          acc_r += (rr * longint'(gr)) >>> 45;
          v_pos[v] = v_pos[v] + 34'(v_step[v]);
        end
      end
      OP_TRIGGER: begin
        if (r.slot >= loaded_reg) res.failed = 1;
        else begin
          k = (((int'(r.pan) + 32768) * PAN_ENTRIES) + 32768) >> 16;
          if (k > PAN_ENTRIES) k = PAN_ENTRIES;
          for (int v = lim - 1; v >= 0; v--) if (!playing[v]) res.chosen = 4'(v);
          v_slot[res.chosen] = r.slot;
          v_pos[res.chosen] = 0;
          v_gain[res.chosen] = r.gain;
          v_step[res.chosen] = r.step;
          v_loop[res.chosen] = r.loop;
          playing[res.chosen] = 1;
          v_lgain[res.chosen] = pan_gain[PAN_ENTRIES - k];
          v_rgain[res.chosen] = pan_gain[k];
        end
      end
      OP_STOP: playing[r.voice] = 0;
      OP_STOP_SLOT: for (int v = 0; v < lim; v++) if (v_slot[v] == r.slot) playing[v] = 0;
      OP_STOP_ALL: for (int v = 0; v < VOICES; v++) playing[v] = 0;
      OP_WR_FRAME: frames[r.addr] = {r.lval, r.rval};
      OP_WR_SLOT: begin
        slot_base[r.slot] = r.addr;
        slot_len[r.slot] = (r.len > 17'd65536) ? 17'd65536 : r.len;
      end
      default: ;
    endcase
    for (int v = 0; v < VOICES; v++) begin
      res.mask[v] = playing[v];
      if (playing[v] && v < lim) res.count++;
    end
    res.left = (acc_l > 32767) ? 16'h7fff : (acc_l < -32768) ? 16'h8000 : acc_l[15:0];
    res.right = (acc_r > 32767) ? 16'h7fff : (acc_r < -32768) ? 16'h8000 : acc_r[15:0];
    return res;
  endfunction

  function automatic request_t random_request(logic [2:0] op);
    request_t r;
    r.op = op;
    r.voice = 4'($urandom);
    r.slot = 6'($urandom);
    r.gain = 16'($urandom);
    r.pan = 16'($urandom);
    r.step = 24'($urandom);
    r.loop = 1'($urandom);
    r.addr = 16'($urandom);
    r.lval = 16'($urandom);
    r.rval = 16'($urandom);
    r.len = 17'($urandom);
    return r;
  endfunction

  task automatic send(request_t r);
    if (r.op == OP_WR_SLOT) slot_safe[r.slot] = (r.len <= 17'd64);
    pending_requests.push_back(r);
    queued_count++;
  endtask

  // Slot inside the pre-written frame regions
  task automatic send_safe_slot(int s, int len);
    request_t r;
    r = random_request(OP_WR_SLOT);
    r.slot = 6'(s);
    r.addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 215)) : 16'($urandom_range(65520, 65535));
    r.len = (len < 0) ? 17'($urandom_range(0, 32)) : 17'(len);
    send(r);
  endtask

  task automatic send_trigger(int s, logic [15:0] gain, logic [15:0] pan, logic [23:0] step,
                              logic loop);
    request_t r;
    r = random_request(OP_TRIGGER);
    r.slot = 6'(s);
    r.gain = gain;
    r.pan = pan;
    r.step = step;
    r.loop = loop;
    send(r);
  endtask

  task automatic send_op(logic [2:0] op);
    send(random_request(op));
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || expected_mixes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    case (idx)
      REG_VOICE_LIMIT: limit_reg = val[4:0];
      REG_MASTER_VOL:  volume_reg = val;
      REG_SLOT_COUNT:  loaded_reg = val[6:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random(int n);
    request_t r;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) r = random_request(OP_TICK);
      else if (pick < 66) begin
        r = random_request(OP_TRIGGER);
        if (r.slot < 64 && !slot_safe[r.slot]) r.slot = 0;
        if ($urandom_range(0, 5) != 0) r.step = 24'($urandom_range(0, 24'h30000));
        if ($urandom_range(0, 7) == 0) r.slot = 6'($urandom_range(0, 3));
      end else if (pick < 71) r = random_request(OP_STOP);
      else if (pick < 76) r = random_request(OP_STOP_SLOT);
      else if (pick < 78) r = random_request(OP_STOP_ALL);
      else if (pick < 88) r = random_request(OP_WR_FRAME);
      else if (pick < 97) begin
        send_safe_slot($urandom_range(0, 63), -1);
        continue;
      end else r = random_request(OP_UNUSED);
      send(r);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_mixes.push_back(predict_mix(on_bus));
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          on_bus = pending_requests.pop_front();
          in_tdata <= {4'd0, on_bus.len, on_bus.rval, on_bus.lval, on_bus.addr, on_bus.loop,
                       on_bus.step, on_bus.pan, on_bus.gain, on_bus.slot, on_bus.voice};
          in_tuser <= on_bus.op;
          in_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    mix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_mixes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_mixes.pop_front();
        if (out_tdata[57:0] !== {want.count, want.mask, want.failed, want.chosen, want.right,
                                 want.left}) begin
          $display("%0t: expected L %h R %h voice %0d fail %b mask %h count %0d, got %h",
                   $time, want.left, want.right, want.chosen, want.failed, want.mask,
                   want.count, out_tdata);
          errors++;
        end
      end
    end
    if (recv_stall > 0) recv_stall--;
    else if (!calm && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 16);
    out_tready <= (recv_stall == 0);
  end

  initial begin
    request_t r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    limit_reg = 5'd16;
    volume_reg = 16'd32768;
    loaded_reg = 7'd0;
    fill_pan_gains();
    for (int v = 0; v < VOICES; v++) begin
      playing[v] = 0; v_slot[v] = 0; v_pos[v] = 0; v_step[v] = 0;
      v_gain[v] = 0; v_loop[v] = 0; v_lgain[v] = 0; v_rgain[v] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // frame regions used by every slot, with full-scale left samples every 37th frame and right every 41st
    for (int a = 0; a < 272; a++) begin
      r = random_request(OP_WR_FRAME);
      r.addr = (a < 256) ? 16'(a) : 16'(65520 + a - 256);
      if (a % 37 == 0) r.lval = 16'sh7fff;
      if (a % 41 == 0) r.rval = -16'sh8000;
      send(r);
    end
    for (int s = 0; s < SLOTS; s++) send_safe_slot(s, -1);
    send_safe_slot(0, 8);
    send_safe_slot(5, 0);
    send_trigger(0, 16'd100, 16'd0, 24'h10000, 1'b0);
    wait_idle();
    write_reg(REG_SLOT_COUNT, 16'd40);
    end_writes();

    send_trigger(50, 16'hffff, 16'h8000, 24'h10000, 1'b0);
    send_trigger(0, 16'hffff, 16'h8000, 24'h08000, 1'b1);
    send_trigger(1, 16'h0000, 16'h7fff, 24'hffffff, 1'b0);
    send_trigger(2, 16'hffff, 16'h0000, 24'h0, 1'b1);
    send_trigger(5, 16'h8000, 16'h7fff, 24'h18000, 1'b0);
    send_trigger(3, 16'hffff, 16'h7fff, 24'hffffff, 1'b1);
    for (int i = 0; i < 6; i++) send_op(OP_TICK);
    r = random_request(OP_STOP);
    r.voice = 4'd1;
    send(r);
    r = random_request(OP_STOP_SLOT);
    r.slot = 6'd0;
    send(r);
    send_op(OP_UNUSED);
    send_op(OP_TICK);
    send_op(OP_STOP_ALL);
    r = random_request(OP_WR_SLOT);
    r.slot = 6'd63;
    r.len = 17'h1ffff;
    send(r);
    send_op(OP_TICK);
    send_safe_slot(63, 20);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_VOICE_LIMIT, 16'd16);
          write_reg(REG_MASTER_VOL, 16'hffff);
          write_reg(REG_SLOT_COUNT, 16'd64);
        end
        1: begin
          write_reg(REG_VOICE_LIMIT, 16'd0);
          write_reg(REG_MASTER_VOL, 16'd0);
        end
        2: begin
          write_reg(REG_VOICE_LIMIT, 16'd31);
          write_reg(REG_MASTER_VOL, 16'($urandom));
          write_reg(REG_SLOT_COUNT, 16'd127);
        end
        3: begin
          write_reg(REG_VOICE_LIMIT, 16'd1);
          write_reg(REG_SLOT_COUNT, 16'd0);
        end
        4: begin
          write_reg(REG_VOICE_LIMIT, 16'd5);
          write_reg(REG_MASTER_VOL, 16'd32768);
          write_reg(REG_SLOT_COUNT, 16'd20);
        end
        default: begin
          write_reg(REG_VOICE_LIMIT, 16'($urandom_range(1, 16)));
          write_reg(REG_MASTER_VOL, 16'($urandom));
          write_reg(REG_SLOT_COUNT, 16'($urandom_range(1, 64)));
        end
      endcase
      end_writes();
      if (ph == 6) calm = 1;
      send_random((ph == 1 || ph == 3) ? 60 : 120);
      wait_idle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== polyphonic_sample_player.f =====
rtl/core/psp_pkg.sv
rtl/core/polyphonic_sample_player.sv
bench/polyphonic_sample_player_test.sv
